FILE: hdl/mrce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrce_pkg: shared types and constants
// Register indexes, pixel flag bundle and fixed field widths of the
// monochrome rectangle color expander.
// ----------------------------------------------------------------------------
package mrce_pkg;

    localparam int COLOR_W    = 32;  // pixel color width
    localparam int CFG_ADDR_W = 3;   // register index width
    localparam int CFG_DATA_W = 32;  // widest register
    localparam int TUSER_W    = 2;

    // m_tuser bit positions
    localparam int TUSER_ROW_END  = 0;
    localparam int TUSER_RECT_END = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FG_COLOR    = 3'd0,
        REG_BG_COLOR    = 3'd1,
        REG_FIRST_BIT   = 3'd2,
        REG_RECT_WIDTH  = 3'd3,
        REG_RECT_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic rect_end;  // last pixel of the rectangle
        logic row_end;   // last pixel of a row
        logic last;      // last pixel taken from the current word
    } pix_flags_t;

endpackage

FILE: hdl/mrce_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrce_cfg: configuration registers
// Write-only register file; presents clamped rectangle limits and the
// start bit reduced into the word.
// ----------------------------------------------------------------------------
module mrce_cfg
    import mrce_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int MAX_DIM   = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    output logic [COLOR_W-1:0]            fg_color,
    output logic [COLOR_W-1:0]            bg_color,
    output logic [$clog2(WORD_BITS)-1:0]  first_bit,
    output logic [$clog2(MAX_DIM):0]      width_lim,
    output logic [$clog2(MAX_DIM):0]      height_lim
);

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int DIMC_W = $clog2(MAX_DIM) + 1;
    localparam logic [BIT_W:0]    WORD_BITS_X = (BIT_W + 1)'(WORD_BITS);
    localparam logic [DIMC_W-1:0] DIM_MAX     = DIMC_W'(MAX_DIM);
    localparam logic [DIMC_W-1:0] DIM_ONE     = DIMC_W'(1);

    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic [BIT_W-1:0]   first_bit_reg;
    logic [DIMC_W-1:0]  width_reg, height_reg;
    logic [BIT_W:0]     fb_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg        <= '0;
            bg_reg        <= '1;
            first_bit_reg <= '0;
            width_reg     <= DIM_ONE;
            height_reg    <= DIM_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FG_COLOR:    fg_reg        <= cfg_wdata[COLOR_W-1:0];
                REG_BG_COLOR:    bg_reg        <= cfg_wdata[COLOR_W-1:0];
                REG_FIRST_BIT:   first_bit_reg <= cfg_wdata[BIT_W-1:0];
                REG_RECT_WIDTH:  width_reg     <= cfg_wdata[DIMC_W-1:0];
                REG_RECT_HEIGHT: height_reg    <= cfg_wdata[DIMC_W-1:0];
                default: ;
            endcase
        end
    end

    // start bit modulo the word size (value is below twice the word size)
    assign fb_ext    = {1'b0, first_bit_reg};
    assign first_bit = (fb_ext >= WORD_BITS_X) ? BIT_W'(fb_ext - WORD_BITS_X)
                                               : first_bit_reg;

    // zero counts as one, oversize counts as the maximum
    assign width_lim  = (width_reg == '0)     ? DIM_ONE :
                        (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
    assign height_lim = (height_reg == '0)     ? DIM_ONE :
                        (height_reg > DIM_MAX) ? DIM_MAX : height_reg;

    assign fg_color = fg_reg;
    assign bg_color = bg_reg;

endmodule

FILE: hdl/mrce_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrce_expand: word holding register and pixel counters
// Holds one source word and walks its bits MSB first, one pixel per
// cycle while pix_ready is high, tracking bit, column and row.
// ----------------------------------------------------------------------------
module mrce_expand
    import mrce_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int MAX_DIM   = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // source words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [WORD_BITS-1:0]          s_word,
    // configuration
    input  logic [COLOR_W-1:0]            fg_color,
    input  logic [COLOR_W-1:0]            bg_color,
    input  logic [$clog2(WORD_BITS)-1:0]  first_bit,
    input  logic [$clog2(MAX_DIM):0]      width_lim,
    input  logic [$clog2(MAX_DIM):0]      height_lim,
    // pixel to the output register
    output logic                          pix_valid,
    input  logic                          pix_ready,
    output logic [COLOR_W-1:0]            pix_color,
    output logic [$clog2(MAX_DIM)-1:0]    pix_col,
    output logic [$clog2(MAX_DIM)-1:0]    pix_row,
    output pix_flags_t                    pix_flags
);

    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int COL_W = $clog2(MAX_DIM);
    localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] word_reg;
    logic                 word_vld_reg, word_vld_next;
    logic [BIT_W-1:0]     bit_pos_reg, bit_pos_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [COL_W-1:0]     row_reg, row_next;

    logic [COL_W:0] col_inc, row_inc;
    logic           row_end, rect_end, word_done, adv, load;
    logic           pix_bit;

    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign row_end   = col_inc >= width_lim;
    assign rect_end  = row_end && (row_inc >= height_lim);
    assign word_done = row_end || (bit_pos_reg == TOP_BIT);
    assign pix_bit   = word_reg[TOP_BIT - bit_pos_reg];

    assign adv      = word_vld_reg && pix_ready;
    assign s_tready = !word_vld_reg || (adv && word_done);
    assign load     = s_tvalid && s_tready;

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        bit_pos_next  = bit_pos_reg;
        word_vld_next = word_vld_reg;
        if (adv) begin
            if (row_end) begin
                col_next     = '0;
                row_next     = rect_end ? '0 : row_inc[COL_W-1:0];
                bit_pos_next = first_bit;
            end else begin
                col_next     = col_inc[COL_W-1:0];
                bit_pos_next = bit_pos_reg + 1'b1;
            end
            if (word_done) begin
                word_vld_next = 1'b0;
            end
        end
        // a word opening a row starts at the configured bit, else at the MSB
        if (load) begin
            word_vld_next = 1'b1;
            bit_pos_next  = (col_next == '0) ? first_bit : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_vld_reg <= 1'b0;
            bit_pos_reg  <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            word_vld_reg <= word_vld_next;
            bit_pos_reg  <= bit_pos_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= s_word;
        end
    end

    assign pix_valid          = word_vld_reg;
    assign pix_color          = pix_bit ? fg_color : bg_color;
    assign pix_col            = col_reg;
    assign pix_row            = row_reg;
    assign pix_flags.rect_end = rect_end;
    assign pix_flags.row_end  = row_end;
    assign pix_flags.last     = word_done;

endmodule

FILE: hdl/mrce_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrce_out_reg: pixel output register
// One-entry output stage; refills in the cycle its pixel is taken.
// ----------------------------------------------------------------------------
module mrce_out_reg
    import mrce_pkg::*;
#(
    parameter int COL_W = 11
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  logic [COLOR_W-1:0] pix_color,
    input  logic [COL_W-1:0]   pix_col,
    input  logic [COL_W-1:0]   pix_row,
    input  pix_flags_t         pix_flags,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COLOR_W-1:0] m_color,
    output logic [COL_W-1:0]   m_col,
    output logic [COL_W-1:0]   m_row,
    output pix_flags_t         m_flags
);

    logic         valid_reg, valid_next;
    logic         take;

    assign pix_ready = !valid_reg || m_ready;
    assign take      = pix_valid && pix_ready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_color <= pix_color;
            m_col   <= pix_col;
            m_row   <= pix_row;
            m_flags <= pix_flags;
        end
    end

    assign m_valid = valid_reg;

endmodule

FILE: hdl/mono_rect_color_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_rect_color_expand: monochrome bitmap color expander
// Expands 1-bit-per-pixel bitmap words into a stream of color pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries bitmap words in row order, bit WORD_BITS-1 leftmost. Each row
//   starts in a fresh word at the configured first bit; every row gives
//   exactly rect_width pixels, the rest of the word that ends a row is dropped.
//   m_* carries one pixel per transfer with its column and row; m_tuser flags
//   the end of a row and of the rectangle, m_tlast the last pixel of a word.
//   Counters wrap to the top-left corner after the last row.
// Timing:
//   A word's first pixel passes the word register, then the output register,
//   on its way to m_*. Pixels leave at one per cycle while m_tready is high
//   and words arrive; a word yields 1 to WORD_BITS pixels (WORD_BITS when rows
//   span whole words). The next word is taken in the cycle its predecessor's
//   last pixel moves to the output register, so words stream without gaps.
// Reset / stall:
//   aresetn (synchronous) empties both registers, zeroes the counters and
//   restores register defaults. When m_tready is low the output pixel holds,
//   the word register stops, and s_tready drops once the word is in use.
//   The user must write registers through cfg_* only while the block is empty.
// ----------------------------------------------------------------------------
module mono_rect_color_expand
    import mrce_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int MAX_DIM   = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // bitmap words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // source_word
    // color pixels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_color, column, row (zero padded)
    output logic [((COLOR_W + 2 * $clog2(MAX_DIM) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [TUSER_W-1:0]    m_tuser,  // row_end, rect_end
    output logic                  m_tlast   // last pixel of the word
);

    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int COL_W       = $clog2(MAX_DIM);
    localparam int DIMC_W      = COL_W + 1;
    localparam int OUT_FIELD_W = COLOR_W + 2 * COL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    logic [COLOR_W-1:0] fg_color, bg_color;
    logic [BIT_W-1:0]   first_bit;
    logic [DIMC_W-1:0]  width_lim, height_lim;

    logic               pix_valid, pix_ready;
    logic [COLOR_W-1:0] pix_color;
    logic [COL_W-1:0]   pix_col, pix_row;
    pix_flags_t         pix_flags;

    logic [COLOR_W-1:0] out_color;
    logic [COL_W-1:0]   out_col, out_row;
    pix_flags_t         out_flags;

    mrce_cfg #(
        .WORD_BITS (WORD_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fg_color   (fg_color),
        .bg_color   (bg_color),
        .first_bit  (first_bit),
        .width_lim  (width_lim),
        .height_lim (height_lim)
    );

    mrce_expand #(
        .WORD_BITS (WORD_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_tdata[WORD_BITS-1:0]),
        .fg_color   (fg_color),
        .bg_color   (bg_color),
        .first_bit  (first_bit),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_color  (pix_color),
        .pix_col    (pix_col),
        .pix_row    (pix_row),
        .pix_flags  (pix_flags)
    );

    mrce_out_reg #(
        .COL_W (COL_W)
    ) u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_color (pix_color),
        .pix_col   (pix_col),
        .pix_row   (pix_row),
        .pix_flags (pix_flags),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_color   (out_color),
        .m_col     (out_col),
        .m_row     (out_row),
        .m_flags   (out_flags)
    );

    // pack result fields, first field lowest
    assign m_tdata = OUT_TDATA_W'({out_row, out_col, out_color});
    assign m_tuser[TUSER_ROW_END]  = out_flags.row_end;
    assign m_tuser[TUSER_RECT_END] = out_flags.rect_end;
    assign m_tlast = out_flags.last;

endmodule

FILE: hdl/mrce_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrce_check: port-level checker
// Watches the top level's ports for ordering of pixel flags and output hold.
// ----------------------------------------------------------------------------
module mrce_check
    import mrce_pkg::*;
#(
    parameter int OUT_W = 56
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [OUT_W-1:0]   m_tdata,
    input logic [TUSER_W-1:0] m_tuser,
    input logic               m_tlast
);

    // a stalled pixel holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output pixel changed while stalled");

    // the rectangle ends only on a row end
    a_rect_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TUSER_RECT_END] |-> m_tuser[TUSER_ROW_END])
        else $error("rect_end without row_end");

    // a row end always closes the current word
    a_row_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TUSER_ROW_END] |-> m_tlast)
        else $error("row_end without last");

    // reset empties the output stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // the word register is empty after reset, so input is open
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input side not open after reset");

endmodule

bind mono_rect_color_expand mrce_check #(
    .OUT_W (OUT_TDATA_W)
) u_mrce_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: dv/mono_rect_color_expand_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_rect_color_expand_tb: self-checking bench for the color expander
// Streams bitmap words into the block under a range of register settings,
// predicts every pixel in a scoreboard class and compares each output
// transfer field by field, with random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
module mono_rect_color_expand_tb;
    import mrce_pkg::*;

    localparam int WORD_W      = 16;    // bitmap word width
    localparam int DIM_MAX     = 2048;  // largest width / height after clamping
    localparam int DRAIN_CYC   = 8;
    localparam int LONG_STALL  = 400;   // long output hold-off
    localparam int WDOG_LIMIT  = 2000;  // cycles without any transfer
    localparam int MAX_REPORTS = 40;    // mismatch lines printed in full

    // one expected / observed pixel
    typedef struct {
        logic [31:0] color;
        logic [10:0] column;
        logic [10:0] row;
        logic        row_end;
        logic        rect_end;
        logic        last;
    } pixel_t;

    // ------------------------------------------------------------------------
    // Pixel predictor and scoreboard. Keeps its own copy of the registers and
    // the bit / column / row counters, expands each accepted word into the
    // pixels it must produce and queues them in order.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [3:0]  first_bit;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        int unsigned bit_pos;
        int unsigned col_cnt;
        int unsigned row_cnt;
        pixel_t      pixel_q[$];
        int          errors;
        int          n_words;
        int          n_pixels;
        int          n_rows;
        int          n_rects;

        function new();
            fg_color   = 32'h0000_0000;
            bg_color   = 32'hFFFF_FFFF;
            first_bit  = 4'd0;
            width_reg  = 12'd1;
            height_reg = 12'd1;
            bit_pos    = 0;
            col_cnt    = 0;
            row_cnt    = 0;
            errors     = 0;
            n_words    = 0;
            n_pixels   = 0;
            n_rows     = 0;
            n_rects    = 0;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        // zero counts as one, anything past the largest size saturates
        function int unsigned clamp_dim(logic [11:0] v);
            if (v == 0) return 1;
            if (v > DIM_MAX) return DIM_MAX;
            return 32'(v);
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] v);
            case (idx)
                REG_FG_COLOR:    fg_color   = v;
                REG_BG_COLOR:    bg_color   = v;
                REG_FIRST_BIT:   first_bit  = v[3:0];
                REG_RECT_WIDTH:  width_reg  = v[11:0];
                REG_RECT_HEIGHT: height_reg = v[11:0];
                default: ;
            endcase
        endfunction

        // accepted input word -> queue of expected pixels
        function void note_word(logic [WORD_W-1:0] w);
            int unsigned w_lim;
            int unsigned h_lim;
            bit          done;
            pixel_t      px;
            w_lim = clamp_dim(width_reg);
            h_lim = clamp_dim(height_reg);
            n_words++;
            // a word that opens a row starts at the configured bit
            if (col_cnt == 0) bit_pos = first_bit;
            done = 1'b0;
            while (!done) begin
                px.color    = w[WORD_W - 1 - bit_pos] ? fg_color : bg_color;
                px.column   = col_cnt[10:0];
                px.row      = row_cnt[10:0];
                px.row_end  = (col_cnt + 1) >= w_lim;
                px.rect_end = px.row_end && ((row_cnt + 1) >= h_lim);
                if (px.row_end) begin
                    // rest of the word is dropped, next word opens a row
                    col_cnt = 0;
                    row_cnt = px.rect_end ? 0 : row_cnt + 1;
                    bit_pos = first_bit;
                    done    = 1'b1;
                    n_rows++;
                    if (px.rect_end) n_rects++;
                end else begin
                    col_cnt++;
                    bit_pos++;
                    if (bit_pos >= WORD_W) begin
                        bit_pos = 0;
                        done    = 1'b1;
                    end
                end
                px.last = done;
                pixel_q.push_back(px);
            end
        endfunction

        function void compare_field(string fld, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: pixel %0d %s mismatch, expected %h, actual %h",
                             $time, n_pixels, fld, want, got);
            end
        endfunction

        // accepted output transfer -> compare with oldest expectation
        function void check_pixel(logic [31:0] color, logic [10:0] column, logic [10:0] row,
                                  logic row_end, logic rect_end, logic last);
            pixel_t want;
            if (pixel_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected pixel, expected none, actual color %h col %0d row %0d",
                             $time, color, column, row);
                return;
            end
            want = pixel_q.pop_front();
            compare_field("color",    want.color,    color);
            compare_field("column",   want.column,   column);
            compare_field("row",      want.row,      row);
            compare_field("row_end",  want.row_end,  row_end);
            compare_field("rect_end", want.rect_end, rect_end);
            compare_field("last",     want.last,     last);
            n_pixels++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_FG_COLOR;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;  // source_word
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;         // pixel_color, column, row (zero padded)
    logic [TUSER_W-1:0]    m_tuser;         // row_end, rect_end
    logic                  m_tlast;         // last pixel of the word

    mono_rect_color_expand DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    pixel_scoreboard sb = new();

    logic [15:0] word_q[$];       // words waiting to be streamed
    int          gap_mode   = 1;  // sender burst / gap profile
    int          rdy_mode   = 0;  // receiver stall profile
    bit          stall_req  = 0;  // ask receiver for one long hold-off
    int          n_settings = 0;
    int          idle_cycles = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: values read here are the ones present before the edge, so
    // both handshakes are seen exactly as the block sees them. The word is
    // noted before the pixel check; a pixel never leaves in the edge its
    // word is taken.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata[31:0], m_tdata[42:32], m_tdata[53:43],
                               m_tuser[TUSER_ROW_END], m_tuser[TUSER_RECT_END], m_tlast);
        end
    end

    // watchdog: any transfer on either side resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d pixels still expected",
                     $time, idle_cycles, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: m_tready follows its own profile. A long hold-off is counted
    // here, while the sender keeps offering words, so the block fills and
    // must drop s_tready.
    // ------------------------------------------------------------------------
    initial begin
        int pat_cnt;
        pat_cnt = 0;
        forever begin
            @(posedge aclk);
            pat_cnt++;
            if (stall_req) begin
                stall_req = 0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end else begin
                case (rdy_mode)
                    0:       m_tready <= 1'b1;                          // never stalls
                    1:       m_tready <= ($urandom_range(0, 3) != 0);  // light stalls
                    2:       m_tready <= ((pat_cnt % 7) < 4);          // fixed pattern
                    default: m_tready <= ($urandom_range(0, 1) != 0);  // heavy stalls
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    function automatic int pick_burst();
        case (gap_mode)
            0:       return 1 << 30;               // one endless burst
            1:       return $urandom_range(1, 6);
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    function automatic int pick_gap();
        case (gap_mode)
            0:       return 0;
            1:       return $urandom_range(1, 4);
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000 >> $urandom_range(0, 15);  // walking one
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // stream word_q in bursts; valid stays high across back-to-back words
    task automatic drive_words();
        int burst;
        int gap;
        burst = pick_burst();
        while (word_q.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= word_q.pop_front();
            do @(posedge aclk); while (!s_tready);
            burst--;
            if (burst == 0) begin
                burst = pick_burst();
                gap   = pick_gap();
                if (gap > 0 && word_q.size() > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // every pending pixel out, then a short drain before touching registers
    task automatic wait_idle();
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic run_phase();
        drive_words();
        wait_idle();
    endtask

    // write all five registers, one per cycle; block is idle here
    task automatic program_regs(input logic [31:0] fg, input logic [31:0] bg,
                                input logic [3:0] fb, input logic [11:0] w,
                                input logic [11:0] h);
        cfg_reg_t    idx[5];
        logic [31:0] val[5];
        idx = '{REG_FG_COLOR, REG_BG_COLOR, REG_FIRST_BIT, REG_RECT_WIDTH, REG_RECT_HEIGHT};
        val = '{fg, bg, 32'(fb), 32'(w), 32'(h)};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            sb.set_reg(idx[i], val[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int          rand_words;
        int          phase;
        int          n;
        int          cw;
        int          ch;
        int          wpr;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [3:0]  fb;
        logic [11:0] wr;
        logic [11:0] hr;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        rdy_mode = 1;
        gap_mode = 1;

        // reset defaults: one pixel per word, fg 0 / bg all ones
        word_q = '{16'h8000, 16'h0000};
        run_phase();

        // whole-word rows, two rows per rectangle
        program_regs(32'hA5A5_5A5A, 32'h0000_0000, 4'd0, 12'd16, 12'd2);
        word_q = '{16'hFFFF, 16'h0000};
        run_phase();

        // start at the LSB: row spans two words, row end inside the second
        rdy_mode = 2;
        program_regs(32'h1234_5678, 32'h8765_4321, 4'd15, 12'd3, 12'd3);
        word_q = '{16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF, 16'h0001, 16'h4000};
        run_phase();

        // zero width and height are taken as one
        rdy_mode = 3;
        program_regs(32'hFFFF_FFFF, 32'h0000_0000, 4'd0, 12'd0, 12'd0);
        word_q = '{16'hFFFF, 16'h7FFF};
        run_phase();

        // oversize width and height saturate; leave the row open
        program_regs(32'h0F0F_F0F0, 32'hF0F0_0F0F, 4'd3, 12'hFFF, 12'hFFF);
        word_q = '{16'hAAAA, 16'h5555, 16'h1234};
        run_phase();

        // shrink width mid-row: column already past it, first pixel ends row
        program_regs(32'hDEAD_BEEF, 32'hCAFE_F00D, 4'd3, 12'd20, 12'd2);
        word_q = '{16'h0F0F};
        run_phase();

        // shrink height below the current row: next row end closes rectangle
        program_regs(32'h0000_0001, 32'h8000_0000, 4'd14, 12'd2, 12'd1);
        word_q = '{16'h4000};
        run_phase();

        // --- random part ---
        rand_words = 0;
        phase      = 0;
        while (rand_words < 205 || phase <= 5) begin
            rdy_mode = $urandom_range(0, 3);
            gap_mode = $urandom_range(0, 2);
            fg = $urandom;
            bg = $urandom;
            fb = 4'($urandom_range(0, 15));
            if (phase == 2) begin
                // one full row at the largest width
                wr = 12'(DIM_MAX);
                hr = 12'd1;
                n  = (fb + DIM_MAX + 15) / 16;
            end else begin
                case ($urandom_range(0, 9))
                    0:       wr = 12'd0;
                    1:       wr = 12'($urandom_range(DIM_MAX + 1, 4095));
                    2, 3:    wr = 12'($urandom_range(1, 4));
                    default: wr = 12'($urandom_range(5, 48));
                endcase
                case ($urandom_range(0, 7))
                    0:       hr = 12'd0;
                    1:       hr = 12'($urandom_range(DIM_MAX + 1, 4095));
                    default: hr = 12'($urandom_range(1, 5));
                endcase
                cw  = (wr == 0) ? 1 : (wr > DIM_MAX) ? DIM_MAX : wr;
                ch  = (hr == 0) ? 1 : (hr > DIM_MAX) ? DIM_MAX : hr;
                wpr = (fb + cw + 15) / 16;
                // mostly whole rectangles, sometimes a cut-off stretch
                if (wpr > 3 || $urandom_range(0, 3) == 0)
                    n = $urandom_range(1, 12);
                else
                    n = wpr * ch * $urandom_range(1, 2);
                if (n > 40) n = 40;
            end
            if (phase == 5) begin
                // sender keeps pushing through a long output hold-off
                stall_req = 1;
                gap_mode  = 0;
                if (n < 24) n = 24;
            end
            program_regs(fg, bg, fb, wr, hr);
            repeat (n) word_q.push_back(rand_word());
            run_phase();
            rand_words += n;
            phase++;
        end

        $display("run covered %0d words, %0d pixels, %0d rows and %0d rectangles over %0d settings",
                 sb.n_words, sb.n_pixels, sb.n_rows, sb.n_rects, n_settings);
        $display("including clamped sizes, mid-rectangle register changes, a full-width row "
                 , "and a long output stall");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d pixels never seen", sb.errors, sb.pending());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: mono_rect_color_expand.f
hdl/mrce_pkg.sv
hdl/mrce_cfg.sv
hdl/mrce_expand.sv
hdl/mrce_out_reg.sv
hdl/mono_rect_color_expand.sv
hdl/mrce_check.sv
dv/mono_rect_color_expand_tb.sv
